### rtl/isr64_pkg.sv
// Shared constants for the 64-bit integer square root core.
`default_nettype none
package isr64_pkg;
  localparam int RADICAND_W       = 64;
  localparam int ROOT_W           = 32;
  localparam int RADICAND_BITS_DEF = 64;
endpackage
`default_nettype wire

### rtl/integer_square_root_64_core.sv
// Top level: pipelined floor square root, one cell per root bit.
// Each start beat passes through every cell in order and leaves the last one as done.
// Throughput: one radicand per cycle; busy is always low, each cell holds one beat.
// Latency is set by the chain length: one cell decides one root bit per cycle.
// Reset (rst, synchronous) clears the valid bit in every cell; data is not reset.
// The receiver cannot stall: done pulses for one cycle with root.
`default_nettype none
module integer_square_root_64_core #(
  parameter int RADICAND_BITS = isr64_pkg::RADICAND_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [isr64_pkg::RADICAND_W-1:0] radicand,
  output logic                               busy,
  output logic                               done,
  output logic [isr64_pkg::ROOT_W-1:0]       root
);
  localparam int RB  = (RADICAND_BITS + 1) / 2;
  localparam int PW  = 2 * RB;
  localparam int RMW = RB + 1;

  logic           vld [0:RB];
  logic [PW-1:0]  rad [0:RB];
  logic [RMW-1:0] rem [0:RB];
  logic [RB-1:0]  q   [0:RB];

  assign busy   = 1'b0;
  assign vld[0] = start;
  assign rad[0] = PW'(radicand[RADICAND_BITS-1:0]);
  assign rem[0] = '0;
  assign q[0]   = '0;

  for (genvar i = 0; i < RB; i++) begin : g_cell
    isr64_cell #(
      .RB  (RB),
      .PW  (PW),
      .RMW (RMW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .vld_in  (vld[i]),
      .rad_in  (rad[i]),
      .rem_in  (rem[i]),
      .q_in    (q[i]),
      .vld_out (vld[i+1]),
      .rad_out (rad[i+1]),
      .rem_out (rem[i+1]),
      .q_out   (q[i+1])
    );
  end

  assign done = vld[RB];
  assign root = isr64_pkg::ROOT_W'(q[RB]);

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##RB done)
    else $error("beat did not reach the end of the chain");
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, RB))
    else $error("result without a matching start");
  a_root_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ((root >> RB) == '0))
    else $error("root has bits above the root width");
`endif
endmodule
`default_nettype wire

### rtl/isr64_cell.sv
// One root-bit cell: brings down two radicand bits and decides one root bit.
`default_nettype none
module isr64_cell #(
  parameter int RB = 32,          // root bits
  parameter int PW = 2 * RB,      // padded radicand width
  parameter int RMW = RB + 1      // remainder width
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           vld_in,
  input  wire logic [PW-1:0]  rad_in,
  input  wire logic [RMW-1:0] rem_in,
  input  wire logic [RB-1:0]  q_in,
  output logic                vld_out,
  output logic [PW-1:0]       rad_out,
  output logic [RMW-1:0]      rem_out,
  output logic [RB-1:0]       q_out
);
  logic [RMW+1:0] partial;
  logic [RMW+1:0] trial;
  logic [RMW+1:0] diff;
  logic           keep;
  logic [RMW-1:0] rem_next;
  logic [RB-1:0]  q_next;
  logic [PW-1:0]  rad_next;

  always_comb begin
    partial  = {rem_in, rad_in[PW-1 -: 2]};
    trial    = (RMW+2)'({q_in, 2'b01});
    diff     = partial - trial;
    keep     = (partial >= trial);
    // remainder stays below 2*(root+1), so it fits RMW bits
    rem_next = keep ? diff[RMW-1:0] : partial[RMW-1:0];
    q_next   = (q_in << 1) | RB'(keep);
    rad_next = rad_in << 2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    rad_out <= rad_next;
    rem_out <= rem_next;
    q_out   <= q_next;
  end
endmodule
`default_nettype wire

### sim/isr64_checker.sv
// Checker for the 64-bit square root core: predicts each root and compares it with done beats.
`timescale 1ns / 1ps
module isr64_checker #(
  parameter int RADICAND_BITS = isr64_pkg::RADICAND_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic [isr64_pkg::RADICAND_W-1:0]  radicand,
  input  logic                              done,
  input  logic [isr64_pkg::ROOT_W-1:0]      root,
  output int                                pending,
  output int                                fail_count
);
  localparam int ROOT_BITS = (RADICAND_BITS + 1) / 2;

  logic [isr64_pkg::ROOT_W-1:0] root_queue[$];
  int                           errors = 0;

  initial begin
    pending    = 0;
    fail_count = 0;
  end

  // Floor root, decided from the top root bit down; only the low RADICAND_BITS are used.
  function automatic logic [isr64_pkg::ROOT_W-1:0] floor_sqrt(
    input logic [isr64_pkg::RADICAND_W-1:0] value
  );
    logic [isr64_pkg::RADICAND_W-1:0] masked;
    logic [isr64_pkg::ROOT_W-1:0]     acc;
    logic [isr64_pkg::ROOT_W-1:0]     trial;
    logic [isr64_pkg::RADICAND_W-1:0] square;
    masked = value & ({isr64_pkg::RADICAND_W{1'b1}}
                      >> (isr64_pkg::RADICAND_W - RADICAND_BITS));
    acc = '0;
    for (int b = ROOT_BITS - 1; b >= 0; b--) begin
      trial  = acc | (isr64_pkg::ROOT_W'(1) << b);
      square = isr64_pkg::RADICAND_W'(trial) * isr64_pkg::RADICAND_W'(trial);
      if (square <= masked) acc = trial;
    end
    return acc;
  endfunction

  always @(posedge clk) begin
    logic [isr64_pkg::ROOT_W-1:0] want;
    if (!rst) begin
      if (done) begin
        if (root_queue.size() == 0) begin
          $error("unexpected done beat: root %h", root);
          errors++;
        end else begin
          want = root_queue.pop_front();
          if (root !== want) begin
            $error("root mismatch: expected %h, actual %h", want, root);
            errors++;
          end
        end
      end
      if (start && !busy) root_queue.push_back(floor_sqrt(radicand));
    end
    pending    <= root_queue.size();
    fail_count <= errors;
  end
endmodule

### sim/tb_integer_square_root_64_core.sv
// Testbench top for the 64-bit square root core: stimulus, reset and verdict.
`timescale 1ns / 1ps
module tb_integer_square_root_64_core;
  localparam int RANDOM_ITEMS = 1400;
  localparam int CALM_TAIL    = 200;
  localparam int DRAIN_CYCLES = 48;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             start = 1'b0;
  logic [isr64_pkg::RADICAND_W-1:0] radicand = '0;
  logic                             busy;
  logic                             done;
  logic [isr64_pkg::ROOT_W-1:0]     root;
  int                               pending;
  int                               fail_count;

  integer_square_root_64_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .radicand (radicand),
    .busy     (busy),
    .done     (done),
    .root     (root)
  );

  isr64_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .radicand   (radicand),
    .done       (done),
    .root       (root),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Holds start high until the beat is taken at an edge with busy low.
  task automatic send_radicand(input logic [isr64_pkg::RADICAND_W-1:0] value);
    start    <= 1'b1;
    radicand <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_burst(input int cycles);
    start    <= 1'b0;
    radicand <= {$urandom, $urandom};
    repeat (cycles) @(posedge clk);
  endtask

  function automatic logic [isr64_pkg::RADICAND_W-1:0] random_radicand();
    logic [isr64_pkg::RADICAND_W-1:0] k;
    logic [isr64_pkg::RADICAND_W-1:0] v;
    int                               pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      // neighborhood of a perfect square, root of random width
      k = isr64_pkg::RADICAND_W'($urandom) >> $urandom_range(0, 31);
      v = k * k;
      case ($urandom_range(0, 3))
        0: v = v - 1;
        1: v = v + 1;
        2: v = v + (k << 1);
        default: ;
      endcase
    end else if (pick < 65) begin
      v = {$urandom, $urandom};
    end else if (pick < 90) begin
      v = {$urandom, $urandom} >> $urandom_range(0, 63);
    end else begin
      v = isr64_pkg::RADICAND_W'($urandom_range(0, 1000));
    end
    return v;
  endfunction

  initial begin
    logic [isr64_pkg::RADICAND_W-1:0] directed[$];
    int                               idle_pct;

    directed = '{
      64'h0, 64'h1, 64'h2, 64'h3, 64'h4, 64'h8, 64'h9, 64'hF, 64'h10,
      64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
      64'hFFFF_FFFE_0000_0001, 64'hFFFF_FFFE_0000_0000,
      64'hFFFF_FFFE_0000_0002,
      64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000,
      64'h3FFF_FFFF_FFFF_FFFF, 64'h0000_0001_0000_0000,
      64'h0000_0000_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA,
      64'h5555_5555_5555_5555, 64'h0000_0000_0001_0000
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_radicand(directed[i]);

    idle_pct = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // idling density shifts every hundred beats; none near the end
      if (i % 100 == 0) idle_pct = (i >= RANDOM_ITEMS - CALM_TAIL) ? 0 : $urandom_range(0, 3) * 20;
      if ($urandom_range(1, 100) <= idle_pct) idle_burst($urandom_range(1, 11));
      send_radicand(random_radicand());
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
